/* sv/des_pkg.sv */
`default_nettype none
package des_pkg;

	localparam int Rounds = 16;

	localparam logic [0:63][6:0] IP_TAB = '{
		58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
	localparam logic [0:63][6:0] FP_TAB = '{
		40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
	localparam logic [0:47][5:0] E_TAB = '{
		32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
		16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
	localparam logic [0:31][5:0] P_TAB = '{
		16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
	localparam logic [0:55][6:0] PC1_TAB = '{
		57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
		60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
		61,53,45,37,29,21,13,5,28,20,12,4};
	localparam logic [0:47][5:0] PC2_TAB = '{
		14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
		41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
	localparam logic [0:15][1:0] ROT_TAB = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
	localparam logic [0:7][0:63][3:0] S_TAB = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	function automatic logic [63:0] ip_perm(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = v[64-IP_TAB[i]];
		return r;
	endfunction

	function automatic logic [63:0] fp_perm(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = v[64-FP_TAB[i]];
		return r;
	endfunction

	function automatic logic [55:0] pc1_perm(input logic [63:0] v);
		logic [55:0] r;
		for (int i = 0; i < 56; i++) r[55-i] = v[64-PC1_TAB[i]];
		return r;
	endfunction

	function automatic logic [47:0] pc2_perm(input logic [55:0] v);
		logic [47:0] r;
		for (int i = 0; i < 48; i++) r[47-i] = v[56-PC2_TAB[i]];
		return r;
	endfunction

	function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] s);
		logic [27:0] r;
		r = (s == 2'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
		return r;
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] sk);
		logic [47:0] x;
		logic [31:0] o;
		logic [31:0] p;
		logic [5:0] six;
		for (int i = 0; i < 48; i++) x[47-i] = r[32-E_TAB[i]];
		x = x ^ sk;
		for (int i = 0; i < 8; i++) begin
			six = x[47-6*i -: 6];
			o[31-4*i -: 4] = S_TAB[i][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < 32; i++) p[31-i] = o[32-P_TAB[i]];
		return p;
	endfunction

endpackage
`default_nettype wire

/* sv/des_block_cipher_unit.sv */
`default_nettype none
// Single-DES engine, one round per pipeline stage: 16 round stages plus an
// input stage (IP) and an output stage (FP), so a block's result appears with
// strobe once it has left the FP stage. busy stays low; a block may start
// every cycle and the receiver cannot stall. The key schedule is computed once
// per key write into sixteen subkey registers; cfg_ready is high when no block
// is in flight and start is low, so a key change never meets a block in flight.
module des_block_cipher_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        command,
	input  wire logic [63:0] data_in,
	output logic             strobe,
	output logic [63:0]      data_out,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [63:0] cfg_data
);
	import des_pkg::*;

	logic [47:0] sub_q [Rounds];
	logic [Rounds+1:0] vld_s;
	logic [31:0] l_s [Rounds+1];
	logic [31:0] r_s [Rounds+1];
	logic dec_s [Rounds+1];
	logic [63:0] m_in;
	logic [63:0] out_q;
	logic [55:0] cd0;
	logic [27:0] c_w [Rounds+1];
	logic [27:0] d_w [Rounds+1];

	assign busy = 1'b0;
	assign cfg_ready = ~start & (vld_s == '0);
	assign m_in = ip_perm(data_in);

	// key schedule from the written key; registered below
	assign cd0 = pc1_perm(cfg_data);
	assign c_w[0] = cd0[55:28];
	assign d_w[0] = cd0[27:0];
	for (genvar g = 0; g < Rounds; g++) begin : g_ks
		assign c_w[g+1] = rot28(c_w[g], ROT_TAB[g]);
		assign d_w[g+1] = rot28(d_w[g], ROT_TAB[g]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Rounds; i++) sub_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < Rounds; i++) sub_q[i] <= pc2_perm({c_w[i+1], d_w[i+1]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else vld_s <= {vld_s[Rounds:0], start};
	end

	always_ff @(posedge clk) begin
		l_s[0] <= m_in[63:32];
		r_s[0] <= m_in[31:0];
		dec_s[0] <= command;
		for (int i = 0; i < Rounds; i++) begin
			l_s[i+1] <= r_s[i];
			r_s[i+1] <= l_s[i] ^ feistel(r_s[i], dec_s[i] ? sub_q[Rounds-1-i] : sub_q[i]);
			dec_s[i+1] <= dec_s[i];
		end
		out_q <= fp_perm({r_s[Rounds], l_s[Rounds]});
	end

	assign strobe = vld_s[Rounds+1];
	assign data_out = out_q;

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> (vld_s == '0))
		else $error("key write with blocks in flight");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##18 strobe)
		else $error("result strobe missing");
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");
endmodule
`default_nettype wire

/* tb/sv/des_block_cipher_unit_tb.sv */
`default_nettype none
module des_block_cipher_unit_tb;
	import des_pkg::*;

	localparam int PipeDepth = 18;
	localparam int StallLimit = 2000;
	localparam logic CmdEncrypt = 1'b0;
	localparam logic CmdDecrypt = 1'b1;

	// Expected ciphertext/plaintext store and its checker
	class des_scoreboard;
		logic [63:0] expected_blocks[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function automatic logic [63:0] des_compute(input logic [63:0] key, input logic dec,
				input logic [63:0] blk);
			logic [47:0] subkeys[16];
			logic [55:0] cd;
			logic [27:0] c;
			logic [27:0] d;
			logic [63:0] m;
			logic [63:0] o;
			logic [55:0] joined;
			logic [47:0] x;
			logic [47:0] sk;
			logic [31:0] l;
			logic [31:0] r;
			logic [31:0] t;
			logic [31:0] sb;
			logic [31:0] f;
			logic [5:0] six;
			int row;
			int col;
			for (int i = 0; i < 56; i++) cd[55-i] = key[64-PC1_TAB[i]];
			c = cd[55:28];
			d = cd[27:0];
			for (int i = 0; i < 16; i++) begin
				repeat (ROT_TAB[i]) begin
					c = {c[26:0], c[27]};
					d = {d[26:0], d[27]};
				end
				joined = {c, d};
				for (int j = 0; j < 48; j++) subkeys[i][47-j] = joined[56-PC2_TAB[j]];
			end
			for (int i = 0; i < 64; i++) m[63-i] = blk[64-IP_TAB[i]];
			l = m[63:32];
			r = m[31:0];
			for (int i = 0; i < 16; i++) begin
				sk = dec ? subkeys[15-i] : subkeys[i];
				for (int j = 0; j < 48; j++) x[47-j] = r[32-E_TAB[j]];
				x = x ^ sk;
				for (int j = 0; j < 8; j++) begin
					six = x[47-6*j -: 6];
					row = {six[5], six[0]};
					col = six[4:1];
					sb[31-4*j -: 4] = S_TAB[j][row*16+col];
				end
				for (int j = 0; j < 32; j++) f[31-j] = sb[32-P_TAB[j]];
				t = l ^ f;
				l = r;
				r = t;
			end
			m = {r, l};
			for (int i = 0; i < 64; i++) o[63-i] = m[64-FP_TAB[i]];
			return o;
		endfunction

		function void note_block(input logic [63:0] key, input logic dec, input logic [63:0] blk);
			expected_blocks.insert(expected_blocks.size(), des_compute(key, dec, blk));
		endfunction

		function void check_block(input logic [63:0] got);
			logic [63:0] want;
			if (expected_blocks.size() == 0) begin
				$display("%0t: unexpected data_out expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_blocks.pop_front();
			if (got !== want) begin
				$display("%0t: data_out mismatch expected %h actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic command = 1'b0;
	logic [63:0] data_in = '0;
	logic strobe;
	logic [63:0] data_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [63:0] cfg_data = '0;

	des_scoreboard sb = new();
	logic [63:0] key_reg = '0;
	int idle_cycles = 0;
	bit no_gaps = 0;

	des_block_cipher_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.data_in(data_in), .strobe(strobe), .data_out(data_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && strobe) sb.check_block(data_out);
	end

	// Watchdog: count cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Hold start high across back-to-back beats; drop it only while idling
	task automatic send_block(input logic cmd, input logic [63:0] blk);
		if (!no_gaps) begin
			while ($urandom_range(99) < 32) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		command <= cmd;
		data_in <= blk;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_block(key_reg, cmd, blk);
	endtask

	task automatic drain_pipe();
		start <= 1'b0;
		while (sb.expected_blocks.size() != 0) @(posedge clk);
		repeat (PipeDepth + 4) @(posedge clk);
	endtask

	task automatic write_key(input logic [63:0] key);
		drain_pipe();
		cfg_valid <= 1'b1;
		cfg_data <= key;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		key_reg = key;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rand_block();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 64'h1 << $urandom_range(63);
			default: return rand64();
		endcase
	endfunction

	initial begin
		logic [63:0] keys[6];
		logic [63:0] ct;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key of zero, then the known-answer vector and extremes
		send_block(CmdEncrypt, 64'h0);
		send_block(CmdDecrypt, 64'h0);
		send_block(CmdEncrypt, '1);
		send_block(CmdDecrypt, '1);
		write_key(64'h133457799BBCDFF1);
		send_block(CmdEncrypt, 64'h0123456789ABCDEF);
		send_block(CmdDecrypt, 64'h85E813540F0AB405);
		send_block(CmdEncrypt, 64'h0);
		send_block(CmdEncrypt, '1);
		send_block(CmdDecrypt, 64'h8000000000000001);
		// parity bits must not matter
		write_key(64'h133457799BBCDFF1 ^ 64'h0101010101010101);
		send_block(CmdEncrypt, 64'h0123456789ABCDEF);
		write_key('1);
		send_block(CmdEncrypt, '1);
		send_block(CmdDecrypt, 64'h0);
		write_key(64'h0101010101010101);
		send_block(CmdEncrypt, 64'h5555555555555555);
		send_block(CmdDecrypt, 64'hAAAAAAAAAAAAAAAA);
		drain_pipe();

		keys[0] = '0;
		keys[1] = '1;
		for (int k = 2; k < 6; k++) keys[k] = rand64();
		for (int ph = 0; ph < 6; ph++) begin
			write_key(keys[ph]);
			no_gaps = (ph == 3);
			for (int n = 0; n < 65; n++) begin
				if ($urandom_range(3) == 0) begin
					// round trip pair
					ct = rand_block();
					send_block(CmdEncrypt, ct);
					send_block(CmdDecrypt, sb.des_compute(key_reg, CmdEncrypt, ct));
					n++;
				end else begin
					send_block(1'($urandom_range(1)), rand_block());
				end
			end
			no_gaps = 0;
		end

		drain_pipe();
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
